// ===== design/dda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg - shared constants and types of the dda line rasterizer
// widths of coordinates, fixed-point accumulator, slope and the divider link
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 16;
   localparam int COLOR_BITS   = 24;
   localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
   localparam int SLOPE_BITS   = FRAC_BITS + 2;
   localparam int QUO_BITS     = FRAC_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

   // input word kinds carried on tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // start request into the iterative divider
   typedef struct packed {
      logic                  start;
      logic [COORD_BITS-1:0] numer;
      logic [COORD_BITS-1:0] denom;
   } div_req_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic                done;
      logic [QUO_BITS-1:0] quotient;
   } div_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } seq_state_type;

endpackage

// ===== design/dda_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_div - restoring divider, one quotient bit per cycle
// computes (numer << FRAC_BITS) / denom with one shared subtractor
// ----------------------------------------------------------------------------
module dda_div import dda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_stat_type stat
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ACC_BITS-1:0]     num_ff, num_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [COORD_BITS-1:0]   den_ff, den_in;
   logic [COORD_BITS-1:0]   rem_ff, rem_in;
   logic [COORD_BITS:0]     rem_shift;
   logic [COORD_BITS:0]     diff;
   logic                    fits;

   // shared subtract and compare
   assign rem_shift = {rem_ff, num_ff[ACC_BITS-1]};
   assign diff      = rem_shift - {1'b0, den_ff};
   assign fits      = !diff[COORD_BITS];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(ACC_BITS - 1);
         num_in  = {req.numer, {FRAC_BITS{1'b0}}};
         den_in  = req.denom;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[ACC_BITS-2:0], 1'b0};
         // upper quotient bits are always zero, so only the low ones are kept
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         rem_in = fits ? diff[COORD_BITS-1:0] : rem_shift[COORD_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   // quotient never exceeds 1.0 in Q.16 since the minor delta is at most the major delta
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// ===== design/dda_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_unit - dda line rasterizer top level
// loads a line, computes its slope with an iterative divider, steps pixels
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser / tlast
//  req     | in  | start_x, start_y, end_x, end_y, line_color | tuser = op
//  rsp     | out | pixel_x, pixel_y, pixel_color              | tuser = pixel_valid,
//          |     |                                            | tlast = last_pixel
//
// steps stream at one pixel per cycle while rsp_tready is high
// a load word emits its start point at once, then holds req_tready low while the
// divider works through all ACC_BITS (28) numerator bits, one quotient bit each, and the slope is latched
// a degenerate load (zero major delta) skips the divider
// reset is synchronous, active high, and clears the sequencer and rsp_tvalid
// a new word is taken only when the result register is empty or draining
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit import dda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // start_x, start_y, end_x, end_y, line_color
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pixel_x, pixel_y, pixel_color
   output logic        rsp_tuser,   // pixel_valid
   output logic        rsp_tlast    // last_pixel
);

   // input word fields
   logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
   logic [COLOR_BITS-1:0] line_color;

   assign start_x    = req_tdata[COORD_BITS-1:0];
   assign start_y    = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign end_x      = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign end_y      = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign line_color = req_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

   // sequencer and line state
   seq_state_type         state_ff, state_in;
   logic                  active_ff, active_in;
   logic                  major_x_ff, major_x_in;
   logic                  neg_ff, neg_in;
   logic [COORD_BITS-1:0] pos_ff, pos_in;
   logic [COORD_BITS-1:0] end_ff, end_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [SLOPE_BITS-1:0] slope_ff, slope_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                  out_pix_ff, out_pix_in;
   logic                  out_last_ff, out_last_in;

   div_req_type  div_req;
   div_stat_type div_stat;

   logic accept;

   // load ordering
   logic [COORD_BITS-1:0] adx, ady;
   logic [COORD_BITS-1:0] ma0, ma1, mi0, mi1, dmaj, dmin;
   logic                  ld_major_x;

   // step arithmetic
   logic [COORD_BITS-1:0] step_pos;
   logic [ACC_BITS-1:0]   step_acc, round_acc;
   logic [COORD_BITS-1:0] step_minor;
   logic                  step_last;
   logic [SLOPE_BITS-1:0] quo_ext;

   assign req_tready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      adx        = (start_x > end_x) ? start_x - end_x : end_x - start_x;
      ady        = (start_y > end_y) ? start_y - end_y : end_y - start_y;
      ld_major_x = (adx >= ady);
      if (ld_major_x) begin
         ma0 = start_x; ma1 = end_x; mi0 = start_y; mi1 = end_y;
      end else begin
         ma0 = start_y; ma1 = end_y; mi0 = start_x; mi1 = end_x;
      end
      // order so the major coordinate increases
      if (ma0 > ma1) begin
         ma0 = ma1; ma1 = ld_major_x ? start_x : start_y;
         mi0 = mi1; mi1 = ld_major_x ? start_y : start_x;
      end
      dmaj = ma1 - ma0;
      dmin = (mi1 >= mi0) ? mi1 - mi0 : mi0 - mi1;
   end

   // one step: advance major, add sign-extended slope, round the minor
   assign step_pos   = pos_ff + 1'b1;
   assign step_acc   = acc_ff + {{(ACC_BITS-SLOPE_BITS){slope_ff[SLOPE_BITS-1]}}, slope_ff};
   assign round_acc  = step_acc + ACC_BITS'(1 << (FRAC_BITS - 1));
   assign step_minor = round_acc[ACC_BITS-1:FRAC_BITS];
   assign step_last  = (step_pos == end_ff);

   assign quo_ext = {1'b0, div_stat.quotient};

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      major_x_in   = major_x_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      color_in     = color_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      div_req      = '{start: 1'b0, numer: dmin, denom: dmaj};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               out_valid_in = 1'b1;
               if (req_tuser == OP_LOAD) begin
                  major_x_in   = ld_major_x;
                  neg_in       = (mi1 < mi0);
                  pos_in       = ma0;
                  end_in       = ma1;
                  acc_in       = {mi0, {FRAC_BITS{1'b0}}};
                  color_in     = line_color;
                  active_in    = (dmaj != '0);
                  // ordered start point; its minor needs no rounding
                  out_x_in     = ld_major_x ? ma0 : mi0;
                  out_y_in     = ld_major_x ? mi0 : ma0;
                  out_color_in = line_color;
                  out_pix_in   = 1'b1;
                  out_last_in  = (dmaj == '0);
                  if (dmaj != '0) begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIVIDE;
                  end
               end else if (active_ff) begin
                  pos_in       = step_pos;
                  acc_in       = step_acc;
                  active_in    = !step_last;
                  out_x_in     = major_x_ff ? step_pos : step_minor;
                  out_y_in     = major_x_ff ? step_minor : step_pos;
                  out_color_in = color_ff;
                  out_pix_in   = 1'b1;
                  out_last_in  = step_last;
               end else begin
                  // step with no line: empty result
                  out_x_in     = '0;
                  out_y_in     = '0;
                  out_color_in = '0;
                  out_pix_in   = 1'b0;
                  out_last_in  = 1'b0;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               // truncated toward zero: negate the magnitude quotient
               slope_in = neg_ff ? SLOPE_BITS'(-quo_ext) : quo_ext;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dda_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      major_x_ff   <= major_x_in;
      neg_ff       <= neg_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      acc_ff       <= acc_in;
      slope_ff     <= slope_in;
      color_ff     <= color_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_pix_ff   <= out_pix_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_color_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== design/dda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_checker - port level checks of the dda line rasterizer
// watches the req and rsp words of the top level through a bind
// ----------------------------------------------------------------------------
module dda_checker import dda_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // every accepted word leaves a result in the output register
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted word produced no result");

   // an empty result carries all zero fields
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("empty result carries data");

   // the final endpoint flag only comes with a real pixel
   a_last_has_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("last flag without a pixel");

   // a stalled result word stays put until it is taken
   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // nothing leaves right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind dda_line_rasterizer_unit dda_checker u_dda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
